### rtl/cbc_pkg.sv
// Shared types and constants for the color blob centroid block.
package cbc_pkg;

	// Frame size limits.
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int COUNT_MAX = MAX_WIDTH * MAX_HEIGHT;
	localparam int CNT_W     = $clog2(COUNT_MAX + 1);
	localparam int SUM_W     = CNT_W + ((COL_W > ROW_W) ? COL_W : ROW_W);

	// Shared divider sizing: pixel divisions use 17-bit dividends, 9-bit divisors.
	localparam int PIX_STEPS = 17;
	localparam int PIX_DVS_W = 9;
	localparam int DIV_N     = (SUM_W > PIX_STEPS) ? SUM_W : PIX_STEPS;
	localparam int DVS_W     = (CNT_W > PIX_DVS_W) ? CNT_W : PIX_DVS_W;
	localparam int STEP_W    = $clog2(DIV_N + 1);

	// Output field widths.
	localparam int CX_W = 11;
	localparam int MC_W = 23;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 30;

	localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VAL_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VAL_HIGH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_THR = 3'd6;

	// Register reset values.
	localparam logic [7:0]            HUE_LOW_RST  = 8'd40;
	localparam logic [7:0]            HUE_HIGH_RST = 8'd80;
	localparam logic [7:0]            SAT_LOW_RST  = 8'd100;
	localparam logic [7:0]            SAT_HIGH_RST = 8'd255;
	localparam logic [7:0]            VAL_LOW_RST  = 8'd100;
	localparam logic [7:0]            VAL_HIGH_RST = 8'd255;
	localparam logic [CFG_DATA_W-1:0] AREA_THR_RST = 30'd1000;

	// Which quantity the shared divider works on.
	typedef enum logic [1:0] {
		DSEL_SAT = 2'd0,
		DSEL_HUE = 2'd1,
		DSEL_X   = 2'd2,
		DSEL_Y   = 2'd3
	} div_sel_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic     latch_px;
		logic     div_start;
		div_sel_t div_sel;
		logic     cap_s;
		logic     cap_h;
		logic     clr_hs;
		logic     acc;
		logic     cap_x;
		logic     cap_y;
		logic     clr_xy;
		logic     load_out;
		logic     clear_frame;
	} cbc_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic d_zero;
		logic frame_end;
		logic found;
		logic div_done;
	} cbc_stat_t;

endpackage

### rtl/cbc_pixel_if.sv
// Pixel input channel.
interface cbc_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;
	logic       row_end;
	logic       frame_end;

	modport source(output valid, blue, green, red, row_end, frame_end, input ready);
	modport sink(input valid, blue, green, red, row_end, frame_end, output ready);
endinterface

### rtl/cbc_result_if.sv
// Centroid result channel.
interface cbc_result_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [10:0] centroid_x;
	logic [10:0] centroid_y;
	logic [22:0] marked_count;

	modport source(output valid, found, centroid_x, centroid_y, marked_count, input ready);
	modport sink(input valid, found, centroid_x, centroid_y, marked_count, output ready);
endinterface

### rtl/cbc_div.sv
// Restoring divider, one quotient bit per cycle.
module cbc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [cbc_pkg::DIV_N-1:0]      dividend,
	input  logic [cbc_pkg::DVS_W-1:0]      divisor,
	input  logic [cbc_pkg::STEP_W-1:0]     steps,
	output logic                           done,
	output logic [cbc_pkg::DIV_N-1:0]      quotient
);

	logic [cbc_pkg::DIV_N-1:0]  dq_q;
	logic [cbc_pkg::DVS_W-1:0]  rem_q;
	logic [cbc_pkg::DVS_W-1:0]  dvs_q;
	logic [cbc_pkg::STEP_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [cbc_pkg::DVS_W:0]    rem_ext;
	logic                       ge;

	// Trial subtraction for one quotient bit.
	always_comb begin
		rem_ext = {rem_q, dq_q[cbc_pkg::DIV_N-1]};
		ge      = rem_ext >= {1'b0, dvs_q};
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == cbc_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? cbc_pkg::DVS_W'(rem_ext - {1'b0, dvs_q})
			            : cbc_pkg::DVS_W'(rem_ext);
			dq_q  <= {dq_q[cbc_pkg::DIV_N-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

### rtl/cbc_ctrl.sv
// Sequencer for pixel conversion, accumulation and frame-end division.
module cbc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  cbc_pkg::cbc_stat_t stat,
	output cbc_pkg::cbc_cmd_t  cmd
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_PREP   = 9'b000000010,
		ST_S_WAIT = 9'b000000100,
		ST_H_WAIT = 9'b000001000,
		ST_ACC    = 9'b000010000,
		ST_FEND   = 9'b000100000,
		ST_X_WAIT = 9'b001000000,
		ST_Y_WAIT = 9'b010000000,
		ST_FIN    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = cbc_pkg::DSEL_SAT;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_px = 1'b1;
					state_d      = ST_PREP;
				end
			end
			ST_PREP: begin
				if (stat.d_zero) begin
					cmd.clr_hs = 1'b1;
					state_d    = ST_ACC;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = cbc_pkg::DSEL_SAT;
					state_d       = ST_S_WAIT;
				end
			end
			ST_S_WAIT: begin
				if (stat.div_done) begin
					cmd.cap_s     = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = cbc_pkg::DSEL_HUE;
					state_d       = ST_H_WAIT;
				end
			end
			ST_H_WAIT: begin
				if (stat.div_done) begin
					cmd.cap_h = 1'b1;
					state_d   = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = stat.frame_end ? ST_FEND : ST_IDLE;
			end
			ST_FEND: begin
				if (stat.found) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = cbc_pkg::DSEL_X;
					state_d       = ST_X_WAIT;
				end else begin
					cmd.clr_xy = 1'b1;
					state_d    = ST_FIN;
				end
			end
			ST_X_WAIT: begin
				cmd.div_sel = cbc_pkg::DSEL_X;
				if (stat.div_done) begin
					cmd.cap_x     = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = cbc_pkg::DSEL_Y;
					state_d       = ST_Y_WAIT;
				end
			end
			ST_Y_WAIT: begin
				cmd.div_sel = cbc_pkg::DSEL_Y;
				if (stat.div_done) begin
					cmd.cap_y = 1'b1;
					state_d   = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.load_out    = 1'b1;
					cmd.clear_frame = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/cbc_dp.sv
// Datapath: HSV conversion, thresholding, moment sums and centroid results.
module cbc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cbc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cbc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [7:0]                        px_blue,
	input  logic [7:0]                        px_green,
	input  logic [7:0]                        px_red,
	input  logic                              px_row_end,
	input  logic                              px_frame_end,
	input  cbc_pkg::cbc_cmd_t                 cmd,
	output cbc_pkg::cbc_stat_t                stat,
	output logic                              res_found,
	output logic [cbc_pkg::CX_W-1:0]          res_cx,
	output logic [cbc_pkg::CX_W-1:0]          res_cy,
	output logic [cbc_pkg::MC_W-1:0]          res_count
);

	localparam int DIV_N = cbc_pkg::DIV_N;
	localparam int DVS_W = cbc_pkg::DVS_W;

	// Configuration registers.
	logic [7:0]                     hue_low_q, hue_high_q, sat_low_q, sat_high_q;
	logic [7:0]                     val_low_q, val_high_q;
	logic [cbc_pkg::CFG_DATA_W-1:0] area_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_low_q  <= cbc_pkg::HUE_LOW_RST;
			hue_high_q <= cbc_pkg::HUE_HIGH_RST;
			sat_low_q  <= cbc_pkg::SAT_LOW_RST;
			sat_high_q <= cbc_pkg::SAT_HIGH_RST;
			val_low_q  <= cbc_pkg::VAL_LOW_RST;
			val_high_q <= cbc_pkg::VAL_HIGH_RST;
			area_thr_q <= cbc_pkg::AREA_THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cbc_pkg::REG_HUE_LOW:  hue_low_q  <= cfg_data[7:0];
				cbc_pkg::REG_HUE_HIGH: hue_high_q <= cfg_data[7:0];
				cbc_pkg::REG_SAT_LOW:  sat_low_q  <= cfg_data[7:0];
				cbc_pkg::REG_SAT_HIGH: sat_high_q <= cfg_data[7:0];
				cbc_pkg::REG_VAL_LOW:  val_low_q  <= cfg_data[7:0];
				cbc_pkg::REG_VAL_HIGH: val_high_q <= cfg_data[7:0];
				cbc_pkg::REG_AREA_THR: area_thr_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Latched pixel.
	logic [7:0] b_q, g_q, r_q;
	logic       row_end_q, frame_end_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_px) begin
			b_q         <= px_blue;
			g_q         <= px_green;
			r_q         <= px_red;
			row_end_q   <= px_row_end;
			frame_end_q <= px_frame_end;
		end
	end

	// Max, min and the hue and saturation numerators.
	logic [7:0]         mx, mn, d;
	logic signed [18:0] rs, gs, bs, ds, num, num_adj;
	logic [16:0]        sat_num, hue_num;

	always_comb begin
		mx = r_q;
		if (g_q > mx) mx = g_q;
		if (b_q > mx) mx = b_q;
		mn = r_q;
		if (g_q < mn) mn = g_q;
		if (b_q < mn) mn = b_q;
		d  = mx - mn;
		rs = signed'(19'(r_q));
		gs = signed'(19'(g_q));
		bs = signed'(19'(b_q));
		ds = signed'(19'(d));
		if (mx == r_q)
			num = 19'sd30 * (gs - bs);
		else if (mx == g_q)
			num = 19'sd60 * ds + 19'sd30 * (bs - rs);
		else
			num = 19'sd120 * ds + 19'sd30 * (rs - gs);
		num_adj = (num < 0) ? num + 19'sd180 * ds : num;
		hue_num = 17'(num_adj * 19'sd2 + ds);
		sat_num = 17'(19'd510 * 19'(d) + 19'(mx));
	end

	// Moment state.
	logic [cbc_pkg::COL_W-1:0] col_q;
	logic [cbc_pkg::ROW_W-1:0] row_q;
	logic [cbc_pkg::CNT_W-1:0] count_q;
	logic [cbc_pkg::SUM_W-1:0] xsum_q, ysum_q;

	// Shared divider operand selection.
	logic [DIV_N-1:0]            div_a;
	logic [DVS_W-1:0]            div_b;
	logic [cbc_pkg::STEP_W-1:0]  div_n;
	logic                        div_done;
	logic [DIV_N-1:0]            div_q;

	always_comb begin
		case (cmd.div_sel)
			cbc_pkg::DSEL_SAT: begin
				div_a = DIV_N'(sat_num) << (DIV_N - cbc_pkg::PIX_STEPS);
				div_b = DVS_W'({mx, 1'b0});
				div_n = cbc_pkg::STEP_W'(cbc_pkg::PIX_STEPS);
			end
			cbc_pkg::DSEL_HUE: begin
				div_a = DIV_N'(hue_num) << (DIV_N - cbc_pkg::PIX_STEPS);
				div_b = DVS_W'({d, 1'b0});
				div_n = cbc_pkg::STEP_W'(cbc_pkg::PIX_STEPS);
			end
			cbc_pkg::DSEL_X: begin
				div_a = DIV_N'(xsum_q);
				div_b = DVS_W'(count_q);
				div_n = cbc_pkg::STEP_W'(DIV_N);
			end
			default: begin
				div_a = DIV_N'(ysum_q);
				div_b = DVS_W'(count_q);
				div_n = cbc_pkg::STEP_W'(DIV_N);
			end
		endcase
	end

	cbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.steps    (div_n),
		.done     (div_done),
		.quotient (div_q)
	);

	// Saturation and hue results.
	logic [7:0] s_q, h_q;
	logic [8:0] hq;

	assign hq = div_q[8:0];

	always_ff @(posedge clk) begin
		if (cmd.clr_hs) begin
			s_q <= '0;
			h_q <= '0;
		end else begin
			if (cmd.cap_s)
				s_q <= div_q[7:0];
			if (cmd.cap_h)
				h_q <= (hq >= 9'd180) ? 8'(hq - 9'd180) : hq[7:0];
		end
	end

	// Threshold test.
	logic marked;

	assign marked = (h_q >= hue_low_q) && (h_q <= hue_high_q) &&
	                (s_q >= sat_low_q) && (s_q <= sat_high_q) &&
	                (mx >= val_low_q) && (mx <= val_high_q) &&
	                (count_q < cbc_pkg::CNT_W'(cbc_pkg::COUNT_MAX));

	// Position counters and moment sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			count_q <= '0;
			xsum_q  <= '0;
			ysum_q  <= '0;
		end else if (cmd.clear_frame) begin
			col_q   <= '0;
			row_q   <= '0;
			count_q <= '0;
			xsum_q  <= '0;
			ysum_q  <= '0;
		end else if (cmd.acc) begin
			if (marked) begin
				count_q <= count_q + 1'b1;
				xsum_q  <= xsum_q + cbc_pkg::SUM_W'(col_q);
				ysum_q  <= ysum_q + cbc_pkg::SUM_W'(row_q);
			end
			if (!frame_end_q) begin
				if (row_end_q) begin
					col_q <= '0;
					if (row_q < cbc_pkg::ROW_W'(cbc_pkg::MAX_HEIGHT - 1))
						row_q <= row_q + 1'b1;
				end else if (col_q < cbc_pkg::COL_W'(cbc_pkg::MAX_WIDTH - 1)) begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Area test on the finished frame.
	logic found;

	assign found = (40'(count_q) * 40'd255) > 40'(area_thr_q);

	// Centroid quotients.
	logic [cbc_pkg::CX_W-1:0] cx_q, cy_q;

	always_ff @(posedge clk) begin
		if (cmd.clr_xy) begin
			cx_q <= '0;
			cy_q <= '0;
		end else begin
			if (cmd.cap_x)
				cx_q <= div_q[cbc_pkg::CX_W-1:0];
			if (cmd.cap_y)
				cy_q <= div_q[cbc_pkg::CX_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_found <= found;
			res_cx    <= cx_q;
			res_cy    <= cy_q;
			res_count <= cbc_pkg::MC_W'(count_q);
		end
	end

	assign stat.d_zero    = (d == 8'd0);
	assign stat.frame_end = frame_end_q;
	assign stat.found     = found;
	assign stat.div_done  = div_done;

endmodule

### rtl/color_blob_centroid.sv
// Top level of the color blob centroid block.
// Pixel transactions are taken one at a time. A pixel whose channels differ passes
// from its acceptance to the next acceptance through the accept state, a setup state,
// two 17-step divisions on the shared restoring divider (saturation, then hue), and
// an accumulate state. A gray pixel skips the divisions. After the last pixel of a
// frame, the block passes through a frame-end state and a finish state when the area
// test fails. When the area test passes, the two 34-step centroid divisions come
// between those two states. The result transaction sits in an output register, so
// the next frame's pixels are taken while it waits. A further frame end then stalls
// until that result has been accepted.
module color_blob_centroid (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data,
	cbc_pixel_if.sink                      pixel,
	cbc_result_if.source                   result
);

	cbc_pkg::cbc_cmd_t  cmd;
	cbc_pkg::cbc_stat_t stat;

	cbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cbc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.px_blue      (pixel.blue),
		.px_green     (pixel.green),
		.px_red       (pixel.red),
		.px_row_end   (pixel.row_end),
		.px_frame_end (pixel.frame_end),
		.cmd          (cmd),
		.stat         (stat),
		.res_found    (result.found),
		.res_cx       (result.centroid_x),
		.res_cy       (result.centroid_y),
		.res_count    (result.marked_count)
	);

endmodule

### bench/testbench.sv
// Self-checking testbench for the color blob centroid block.
module testbench;

	// Index with no register behind it; writes to it must be ignored.
	localparam logic [cbc_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 200;

	typedef struct packed {
		logic        found;
		logic [10:0] cx;
		logic [10:0] cy;
		logic [22:0] count;
	} centroid_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [cbc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data;

	cbc_pixel_if  pixel();
	cbc_result_if result();

	color_blob_centroid dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pixel(pixel), .result(result)
	);

	// Shadow configuration and frame accumulators.
	int unsigned hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi, area_thr;
	int unsigned col_pos, row_pos;
	longint unsigned marked, x_acc, y_acc;

	centroid_t pending_centroids[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit steady_flow = 0;

	// Clock.
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	task automatic report(input string what, input int unsigned got, input int unsigned want);
		$display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	// Integer HSV conversion with hue in two-degree steps.
	function automatic void to_hsv(input int b, input int g, input int r,
			output int h, output int s, output int v);
		int mx, mn, d, num;
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		v = mx;
		d = mx - mn;
		if (d == 0) begin
			s = 0;
			h = 0;
			return;
		end
		s = (510 * d + mx) / (2 * mx);
		if (mx == r) num = 30 * (g - b);
		else if (mx == g) num = 60 * d + 30 * (b - r);
		else num = 120 * d + 30 * (r - g);
		if (num < 0) num += 180 * d;
		h = (2 * num + d) / (2 * d);
		if (h >= 180) h -= 180;
	endfunction

	// Accumulates one accepted pixel and queues the centroid at frame end.
	function automatic void accumulate_pixel(input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r, input logic re, input logic fe);
		int h, s, v;
		centroid_t c;
		to_hsv(int'(b), int'(g), int'(r), h, s, v);
		if (h >= hue_lo && h <= hue_hi && s >= sat_lo && s <= sat_hi &&
				v >= val_lo && v <= val_hi && marked < cbc_pkg::COUNT_MAX) begin
			marked++;
			x_acc += col_pos;
			y_acc += row_pos;
		end
		if (fe) begin
			c.found = (255 * marked) > area_thr;
			c.cx = (c.found && marked != 0) ? 11'(x_acc / marked) : '0;
			c.cy = (c.found && marked != 0) ? 11'(y_acc / marked) : '0;
			c.count = 23'(marked);
			pending_centroids.push_back(c);
			col_pos = 0; row_pos = 0;
			marked = 0; x_acc = 0; y_acc = 0;
		end else if (re) begin
			col_pos = 0;
			if (row_pos < cbc_pkg::MAX_HEIGHT - 1) row_pos++;
		end else if (col_pos < cbc_pkg::MAX_WIDTH - 1) begin
			col_pos++;
		end
	endfunction

	// Mostly short gaps, a few long ones, none during steady stretches.
	function automatic int pick_gap();
		int p;
		if (steady_flow) return 0;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Register write; the block is idle whenever this is called.
	task automatic write_reg(input logic [cbc_pkg::CFG_IDX_W-1:0] idx,
			input logic [cbc_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			cbc_pkg::REG_HUE_LOW:  hue_lo = val[7:0];
			cbc_pkg::REG_HUE_HIGH: hue_hi = val[7:0];
			cbc_pkg::REG_SAT_LOW:  sat_lo = val[7:0];
			cbc_pkg::REG_SAT_HIGH: sat_hi = val[7:0];
			cbc_pkg::REG_VAL_LOW:  val_lo = val[7:0];
			cbc_pkg::REG_VAL_HIGH: val_hi = val[7:0];
			cbc_pkg::REG_AREA_THR: area_thr = 32'(val);
			default: ;
		endcase
	endtask

	// Sends one pixel transaction, then idles for a random gap.
	task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
			input logic re, input logic fe);
		int gap;
		pixel.valid <= 1'b1;
		pixel.blue <= b;
		pixel.green <= g;
		pixel.red <= r;
		pixel.row_end <= re;
		pixel.frame_end <= fe;
		do @(posedge clk); while (!pixel.ready);
		accumulate_pixel(b, g, r, re, fe);
		gap = pick_gap();
		if (gap > 0) begin
			pixel.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering pixels, then waits until every centroid has arrived and the
	// block has gone quiet.
	task automatic drain();
		pixel.valid <= 1'b0;
		while (pending_centroids.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random frame of small size with optional irregular row ends.
	task automatic random_frame(input int max_w, input int max_h, output int count);
		int w, h;
		logic [7:0] b, g, r;
		w = $urandom_range(1, max_w);
		h = $urandom_range(1, max_h);
		steady_flow = ($urandom_range(0, 4) == 0);
		for (int y = 0; y < h; y++) begin
			for (int x = 0; x < w; x++) begin
				b = 8'($urandom); g = 8'($urandom); r = 8'($urandom);
				if ($urandom_range(0, 7) == 0) begin
					g = r; b = r;
				end
				send_pixel(b, g, r, (x == w - 1) || ($urandom_range(0, 19) == 0),
					(x == w - 1) && (y == h - 1));
			end
		end
		steady_flow = 0;
		count = w * h;
	endtask

	// Default bounds: primaries, gray extremes and hue wrap cases.
	task automatic test_directed_colors();
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd255, 1'b0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b1, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
		send_pixel(8'd1, 8'd0, 8'd255, 1'b0, 1'b0);    // hue rounds up to 180, wraps to 0
		send_pixel(8'd200, 8'd0, 8'd255, 1'b0, 1'b0);  // red max with negative numerator
		send_pixel(8'd40, 8'd200, 8'd60, 1'b1, 1'b0);
		send_pixel(8'd10, 8'd250, 8'd30, 1'b0, 1'b0);
		send_pixel(8'd0, 8'd1, 8'd1, 1'b0, 1'b0);
		send_pixel(8'd128, 8'd128, 8'd127, 1'b0, 1'b0);
		send_pixel(8'd20, 8'd230, 8'd20, 1'b0, 1'b1);
		// One-pixel frames: marked and unmarked.
		send_pixel(8'd20, 8'd230, 8'd20, 1'b0, 1'b1);
		send_pixel(8'd20, 8'd20, 8'd230, 1'b1, 1'b1);
		// Frame end after a few rows of green.
		for (int i = 0; i < 8; i++)
			send_pixel(8'd30, 8'd255 - 8'(i), 8'd50, i % 3 == 2, i == 7);
		drain();
	endtask

	// Area threshold at zero, at its maximum and at 254, plus a write to an unused index.
	task automatic test_area_extremes();
		write_reg(cbc_pkg::REG_AREA_THR, '0);
		send_pixel(8'd20, 8'd230, 8'd20, 1'b0, 1'b1);
		send_pixel(8'd20, 8'd20, 8'd230, 1'b0, 1'b1);
		drain();
		write_reg(cbc_pkg::REG_AREA_THR, '1);
		for (int i = 0; i < 4; i++)
			send_pixel(8'd20, 8'd230, 8'd20, 1'b0, i == 3);
		drain();
		write_reg(REG_NONE, '1);
		write_reg(cbc_pkg::REG_AREA_THR, 30'd254);
		send_pixel(8'd20, 8'd230, 8'd20, 1'b1, 1'b0);
		send_pixel(8'd20, 8'd231, 8'd20, 1'b0, 1'b1);
		drain();
	endtask

	// Random frames under several bound settings, extremes included.
	task automatic test_random_frames();
		int sent;
		int n;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					write_reg(cbc_pkg::REG_HUE_LOW, '0); write_reg(cbc_pkg::REG_HUE_HIGH, '1);
					write_reg(cbc_pkg::REG_SAT_LOW, '0); write_reg(cbc_pkg::REG_SAT_HIGH, '1);
					write_reg(cbc_pkg::REG_VAL_LOW, '0); write_reg(cbc_pkg::REG_VAL_HIGH, '1);
					write_reg(cbc_pkg::REG_AREA_THR, '0);
				end
				1: begin
					write_reg(cbc_pkg::REG_HUE_LOW, 30'd179);
					write_reg(cbc_pkg::REG_HUE_HIGH, 30'd0);
					write_reg(cbc_pkg::REG_AREA_THR, 30'h2AAAAAAA);
				end
				2: begin
					write_reg(cbc_pkg::REG_HUE_LOW, 30'd0);
					write_reg(cbc_pkg::REG_HUE_HIGH, 30'd179);
					write_reg(cbc_pkg::REG_SAT_LOW, 30'd255);
					write_reg(cbc_pkg::REG_VAL_LOW, 30'd255);
					write_reg(cbc_pkg::REG_AREA_THR, 30'h15555555);
				end
				default: begin
					write_reg(cbc_pkg::REG_HUE_LOW, 30'($urandom_range(0, 120)));
					write_reg(cbc_pkg::REG_HUE_HIGH, 30'(hue_lo + $urandom_range(0, 100)));
					write_reg(cbc_pkg::REG_SAT_LOW, 30'($urandom_range(0, 150)));
					write_reg(cbc_pkg::REG_SAT_HIGH, 30'($urandom_range(150, 255)));
					write_reg(cbc_pkg::REG_VAL_LOW, 30'($urandom_range(0, 150)));
					write_reg(cbc_pkg::REG_VAL_HIGH,
						{22'($urandom_range(0, 4194303)), 8'd255});
					write_reg(cbc_pkg::REG_AREA_THR, 30'($urandom_range(0, 3) == 0 ?
						$urandom : $urandom_range(0, 3000)));
				end
			endcase
			sent = 0;
			while (sent < 95) begin
				random_frame(10, 5, n);
				sent += n;
			end
			drain();
		end
	endtask

	// A long row and a tall frame of one pixel per row, every pixel marked.
	task automatic test_long_lines();
		logic [7:0] v;
		write_reg(cbc_pkg::REG_HUE_LOW, '0); write_reg(cbc_pkg::REG_HUE_HIGH, 30'd179);
		write_reg(cbc_pkg::REG_SAT_LOW, '0); write_reg(cbc_pkg::REG_SAT_HIGH, 30'd255);
		write_reg(cbc_pkg::REG_VAL_LOW, '0); write_reg(cbc_pkg::REG_VAL_HIGH, 30'd255);
		write_reg(cbc_pkg::REG_AREA_THR, '0);
		steady_flow = 1;
		for (int i = 0; i < 200; i++) begin
			v = 8'($urandom);
			send_pixel(v, v, v, 1'b0, i == 199);
		end
		for (int i = 0; i < 70; i++) begin
			v = 8'($urandom);
			send_pixel(v, v, v, 1'b1, i == 69);
		end
		steady_flow = 0;
		drain();
	endtask

	// Sink side: random stalls, some long, with stretches of no stall.
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			stall_left <= 0;
		end else if (steady_flow || stall_left == 0) begin
			result.ready <= 1'b1;
			if (!steady_flow && $urandom_range(0, 9) == 0)
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 4);
		end else begin
			result.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end
	end

	// Compares each centroid transaction with the oldest expectation.
	always @(posedge clk) begin
		centroid_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_centroids.size() == 0) begin
				$display("unexpected centroid transaction at %0t", $time);
				mismatch_count++;
			end else begin
				want = pending_centroids.pop_front();
				if (result.found !== want.found)
					report("found", 32'(result.found), 32'(want.found));
				if (result.centroid_x !== want.cx)
					report("centroid_x", 32'(result.centroid_x), 32'(want.cx));
				if (result.centroid_y !== want.cy)
					report("centroid_y", 32'(result.centroid_y), 32'(want.cy));
				if (result.marked_count !== want.count)
					report("marked_count", 32'(result.marked_count), 32'(want.count));
			end
		end
	end

	// Watchdog over cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((pixel.valid && pixel.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pixel.valid = 1'b0;
		pixel.blue = '0;
		pixel.green = '0;
		pixel.red = '0;
		pixel.row_end = 1'b0;
		pixel.frame_end = 1'b0;
		hue_lo = cbc_pkg::HUE_LOW_RST; hue_hi = cbc_pkg::HUE_HIGH_RST;
		sat_lo = cbc_pkg::SAT_LOW_RST; sat_hi = cbc_pkg::SAT_HIGH_RST;
		val_lo = cbc_pkg::VAL_LOW_RST; val_hi = cbc_pkg::VAL_HIGH_RST;
		area_thr = 32'(cbc_pkg::AREA_THR_RST);
		col_pos = 0; row_pos = 0;
		marked = 0; x_acc = 0; y_acc = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_colors();
		test_area_extremes();
		test_random_frames();
		test_long_lines();
		pixel.valid <= 1'b0;
		drain();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
